/* src/b64e_pkg.sv */
// Shared types, constants and the alphabet function of the base64 encoder.
`default_nettype none
package b64e_pkg;

    // Depth of the symbol-job queue between front and back.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // One job: up to four 6-bit symbols or pads for a single input byte.
    typedef struct packed {
        logic [3:0][5:0] sym;
        logic [3:0]      is_pad;
        logic [1:0]      last_slot;   // index of the final slot used
        logic            last;        // job ends the message
    } b64e_job_t;

    // Standard alphabet: A-Z a-z 0-9 + /
    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] c;
        c = 8'h2F;
        if (v inside {[6'd0:6'd25]})
            c = 8'h41 + {2'b00, v};
        else if (v inside {[6'd26:6'd51]})
            c = 8'h61 + {2'b00, v} - 8'd26;
        else if (v inside {[6'd52:6'd61]})
            c = 8'h30 + {2'b00, v} - 8'd52;
        else if (v == 6'd62)
            c = 8'h2B;
        return c;
    endfunction

endpackage
`default_nettype wire

/* src/b64e_front.sv */
// Front end: takes bytes, tracks group phase and carry, builds symbol jobs.
`default_nettype none
module b64e_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               accept,
    input  wire logic [7:0]         in_byte,
    input  wire logic               final_byte,
    input  wire logic               cfg_valid,
    input  wire logic               pad_enable,
    output b64e_pkg::b64e_job_t     job,
    output logic                    job_push
);
    import b64e_pkg::*;

    typedef enum logic [2:0] {
        PH0 = 3'b001,
        PH1 = 3'b010,
        PH2 = 3'b100
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [3:0] carry_reg, carry_next;
    logic       pad_reg;

    always_comb
    begin
        job        = '0;
        job.last   = final_byte;
        phase_next = PH0;
        carry_next = 4'd0;
        case (phase_reg)
            PH1:
            begin
                job.sym[0] = {carry_reg[1:0], in_byte[7:4]};
                if (final_byte)
                begin
                    job.sym[1]    = {in_byte[3:0], 2'b00};
                    job.is_pad[2] = pad_reg;
                    job.last_slot = pad_reg ? 2'd2 : 2'd1;
                end
                else
                begin
                    phase_next = PH2;
                    carry_next = in_byte[3:0];
                end
            end
            PH2:
            begin
                job.sym[0]    = {carry_reg, in_byte[7:6]};
                job.sym[1]    = in_byte[5:0];
                job.last_slot = 2'd1;
            end
            default:
            begin
                job.sym[0] = in_byte[7:2];
                if (final_byte)
                begin
                    job.sym[1]    = {in_byte[1:0], 4'b0000};
                    job.is_pad[2] = pad_reg;
                    job.is_pad[3] = pad_reg;
                    job.last_slot = pad_reg ? 2'd3 : 2'd1;
                end
                else
                begin
                    phase_next = PH1;
                    carry_next = {2'b00, in_byte[1:0]};
                end
            end
        endcase
    end

    assign job_push = accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH0;
            carry_reg <= 4'd0;
            pad_reg   <= 1'b1;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
                carry_reg <= carry_next;
            end
            if (cfg_valid)
                pad_reg <= pad_enable;
        end
    end

endmodule
`default_nettype wire

/* src/b64e_queue.sv */
// Short job queue between the front and back ends.
`default_nettype none
module b64e_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                wr_en,
    input  b64e_pkg::b64e_job_t      wr_job,
    input  wire logic                rd_en,
    output b64e_pkg::b64e_job_t      rd_job,
    output logic                     q_full,
    output logic                     q_empty
);
    import b64e_pkg::*;

    b64e_job_t           mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg, count_next;

    assign q_full  = (count_reg == QCNT_W'(QDEPTH));
    assign q_empty = (count_reg == '0);
    assign rd_job  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
            count_next = count_reg + 1'b1;
        else if (rd_en && !wr_en)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

/* src/b64e_back.sv */
// Back end: walks job slots into output register, one char per cycle if free or popped.
`default_nettype none
module b64e_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  b64e_pkg::b64e_job_t      head,
    input  wire logic                q_empty,
    output logic                     q_pop,
    input  wire logic                pop,
    output logic                     empty,
    output logic [7:0]               out_char,
    output logic                     out_last
);
    import b64e_pkg::*;

    logic [1:0] slot_reg;
    logic       valid_reg;
    logic [7:0] char_reg;
    logic       last_reg;
    logic       load;
    logic       end_of_job;
    logic [7:0] char_next;

    assign load       = !q_empty && (!valid_reg || pop);
    assign end_of_job = (slot_reg == head.last_slot);
    assign q_pop      = load && end_of_job;
    assign char_next  = head.is_pad[slot_reg] ? PAD_CHAR : b64_char(head.sym[slot_reg]);

    assign empty    = !valid_reg;
    assign out_char = char_reg;
    assign out_last = last_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg <= char_next;
            last_reg <= head.last && end_of_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg  <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                slot_reg <= end_of_job ? 2'd0 : slot_reg + 2'd1;
            if (load)
                valid_reg <= 1'b1;
            else if (pop)
                valid_reg <= 1'b0;
        end
    end

endmodule
`default_nettype wire

/* src/base64_encoder.sv */
// Top level of the streaming base64 encoder.
// Base64 encoder, standard alphabet. Bytes go in through a queue-style port
// (push/full), one byte per transaction, with final_byte set on the last byte
// of a message. Characters come out through a queue-style port (empty/pop),
// one ASCII character per transaction; out_last marks the last character of
// a message. With pad_enable set (reset value) a final partial group is
// filled with '=' characters. pad_enable is written through the cfg channel
// (cfg_valid/cfg_ready, ready is always high) and should only change while
// no message is in flight.
// Throughput: the front end takes one byte per cycle unless full is high; the
// back end emits one character per cycle while the output is free or popped.
// A byte produces one or two characters mid-message and up to four for a
// padded final byte, which over a long message averages 4/3 characters per
// byte. A 4-entry job queue sits between the two ends; full rises once the
// back end falls behind the input, either under pop stalls or over a long
// run of bytes with pop held high. An accepted byte goes first into the job
// queue and then its first character into the output register.
`default_nettype none
module base64_encoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // byte input
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  in_byte,
    input  wire logic        final_byte,
    // character output
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       out_char,
    output logic             out_last,
    // configuration
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        pad_enable
);
    import b64e_pkg::*;

    b64e_job_t  job;
    b64e_job_t  head;
    logic       job_push;
    logic       q_pop;
    logic       q_full;
    logic       q_empty;
    logic       accept;

    assign full      = q_full;
    assign accept    = push && !q_full;
    assign cfg_ready = 1'b1;

    // Front: phase/carry tracking and symbol extraction per byte.
    b64e_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .in_byte    (in_byte),
        .final_byte (final_byte),
        .cfg_valid  (cfg_valid),
        .pad_enable (pad_enable),
        .job        (job),
        .job_push   (job_push)
    );

    // Decoupling queue of per-byte jobs.
    b64e_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_job  (job),
        .rd_en   (q_pop),
        .rd_job  (head),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    // Back: alphabet lookup, padding, one char per cycle while output is free or popped.
    b64e_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .pop      (pop),
        .empty    (empty),
        .out_char (out_char),
        .out_last (out_last)
    );

    // A job is never written into a full queue.
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> !q_full)
        else $error("job pushed into full queue");

    // The back end only retires a job that is present.
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("job popped from empty queue");

    // Padding only ever fills the two tail slots of a job.
    a_pad_tail: assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> (!job.is_pad[0] && !job.is_pad[1]))
        else $error("pad in leading slot");

endmodule
`default_nettype wire
